// ----- src/line_clip_outcode_defines.svh -----
// Assertion macros shared by the line clip RTL.
// Needs clk_i and rst_ni in the module that uses them.
`ifndef LINE_CLIP_OUTCODE_DEFINES_SVH
`define LINE_CLIP_OUTCODE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lco_pkg.sv -----
// Shared types, constants and outcode function for the line clipper.
// No dependencies.
package lco_pkg;

  localparam int LCO_FRAC_BITS  = 16;
  localparam int LCO_MAX_PASSES = 8;
  localparam int LCO_CFG_IDX_W  = 2;
  localparam int LCO_BOUND_W    = 13;
  localparam int LCO_CW_MAX     = 39;  // coordinate width at the largest fraction width

  localparam logic [3:0] OC_LEFT   = 4'h1;
  localparam logic [3:0] OC_TOP    = 4'h2;
  localparam logic [3:0] OC_RIGHT  = 4'h4;
  localparam logic [3:0] OC_BOTTOM = 4'h8;

  typedef enum logic [LCO_CFG_IDX_W-1:0] {
    CFG_LEFT   = 2'd0,
    CFG_TOP    = 2'd1,
    CFG_RIGHT  = 2'd2,
    CFG_BOTTOM = 2'd3
  } lco_cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_UPD,
    S_OUT
  } lco_state_e;

  // Internal signed coordinate width: holds a 32-bit input and a shifted bound.
  function automatic int lco_coord_w(input int frac);
    return (frac + 15 > 33) ? frac + 15 : 33;
  endfunction

  function automatic logic [3:0] lco_outcode(
    input logic signed [LCO_CW_MAX-1:0] x,
    input logic signed [LCO_CW_MAX-1:0] y,
    input logic signed [LCO_CW_MAX-1:0] xmin,
    input logic signed [LCO_CW_MAX-1:0] ymin,
    input logic signed [LCO_CW_MAX-1:0] xmax,
    input logic signed [LCO_CW_MAX-1:0] ymax
  );
    logic [3:0] c;
    c = '0;
    if (x < xmin) c = c | OC_LEFT;
    if (y < ymin) c = c | OC_TOP;
    if (x > xmax) c = c | OC_RIGHT;
    if (y > ymax) c = c | OC_BOTTOM;
    return c;
  endfunction

endpackage

// ----- src/lco_fifo.sv -----
// Two-entry register queue between the classifier and the clip engine.
// Depends on nothing.
module lco_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] head_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

// ----- src/lco_front.sv -----
// Front end: takes input transfers, computes both outcodes, pushes the queue.
// Depends on lco_pkg.
module lco_front import lco_pkg::*; #(
  parameter int FRAC_BITS = LCO_FRAC_BITS,
  localparam int CW = lco_coord_w(FRAC_BITS),
  localparam int EW = 4 * CW + 8
) (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [31:0]   start_x_i,
  input  logic signed [31:0]   start_y_i,
  input  logic signed [31:0]   end_x_i,
  input  logic signed [31:0]   end_y_i,
  input  logic signed [CW-1:0] xmin_i,
  input  logic signed [CW-1:0] ymin_i,
  input  logic signed [CW-1:0] xmax_i,
  input  logic signed [CW-1:0] ymax_i,
  input  logic                 full_i,
  output logic                 push_o,
  output logic [EW-1:0]        push_data_o
);
  logic signed [CW-1:0] x1, y1, x2, y2;
  logic [3:0] c1, c2;

  assign x1 = CW'(start_x_i);
  assign y1 = CW'(start_y_i);
  assign x2 = CW'(end_x_i);
  assign y2 = CW'(end_y_i);

  assign c1 = lco_outcode(LCO_CW_MAX'(x1), LCO_CW_MAX'(y1), LCO_CW_MAX'(xmin_i),
                          LCO_CW_MAX'(ymin_i), LCO_CW_MAX'(xmax_i), LCO_CW_MAX'(ymax_i));
  assign c2 = lco_outcode(LCO_CW_MAX'(x2), LCO_CW_MAX'(y2), LCO_CW_MAX'(xmin_i),
                          LCO_CW_MAX'(ymin_i), LCO_CW_MAX'(xmax_i), LCO_CW_MAX'(ymax_i));

  assign in_ready_o  = ~full_i;
  assign push_o      = in_valid_i & ~full_i;
  assign push_data_o = {c1, c2, x1, y1, x2, y2};
endmodule

// ----- src/lco_back.sv -----
// Back end: iterative clip engine with a bit-serial multiplier and divider.
// Depends on lco_pkg and line_clip_outcode_defines.svh.
`include "line_clip_outcode_defines.svh"
module lco_back import lco_pkg::*; #(
  parameter int FRAC_BITS  = LCO_FRAC_BITS,
  parameter int MAX_PASSES = LCO_MAX_PASSES,
  localparam int CW = lco_coord_w(FRAC_BITS),
  localparam int EW = 4 * CW + 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic signed [CW-1:0] xmin_i,
  input  logic signed [CW-1:0] ymin_i,
  input  logic signed [CW-1:0] xmax_i,
  input  logic signed [CW-1:0] ymax_i,
  input  logic                 empty_i,
  input  logic [EW-1:0]        head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 rejected_o,
  output logic signed [31:0]   clipped_start_x_o,
  output logic signed [31:0]   clipped_start_y_o,
  output logic signed [31:0]   clipped_end_x_o,
  output logic signed [31:0]   clipped_end_y_o
);
  localparam int DW  = CW + 1;       // differences and magnitudes
  localparam int PW  = 2 * DW;       // product
  localparam int CNW = $clog2(PW);
  localparam int PSW = $clog2(MAX_PASSES + 1);

  lco_state_e state_q, state_d;

  logic signed [CW-1:0] x1_q, y1_q, x2_q, y2_q, bound_q;
  logic [3:0]           c1_q, c2_q;
  logic                 sel_x_q, neg_q;
  logic [DW-1:0]        mag_b_q, mag_d_q, q_q;
  logic [PW-1:0]        mcand_q, prod_q;
  logic [DW:0]          rem_q;
  logic [CNW-1:0]       cnt_q;
  logic [PSW-1:0]       passes_q;
  logic                 out_valid_q, rej_q;
  logic signed [31:0]   ox1_q, oy1_q, ox2_q, oy2_q;

  // Pass setup: swap so the outside point is first, pick the edge.
  logic                 done, sw, sel_x;
  logic [3:0]           ec1;
  logic signed [CW-1:0] ex1, ey1, ex2, ey2, bnd, pa, pb, ea, eb;
  logic signed [DW-1:0] d_other, to_bnd, d_edge;

  always_comb begin
    done  = ((c1_q | c2_q) == 4'h0) || ((c1_q & c2_q) != 4'h0) ||
            (passes_q == PSW'(MAX_PASSES));
    sw    = (c1_q == 4'h0);
    ex1   = sw ? x2_q : x1_q;
    ey1   = sw ? y2_q : y1_q;
    ex2   = sw ? x1_q : x2_q;
    ey2   = sw ? y1_q : y2_q;
    ec1   = sw ? c2_q : c1_q;
    sel_x = ((ec1 & OC_LEFT) != 4'h0) ||
            (((ec1 & OC_TOP) == 4'h0) && ((ec1 & OC_RIGHT) != 4'h0));
    if ((ec1 & OC_LEFT) != 4'h0)       bnd = xmin_i;
    else if ((ec1 & OC_TOP) != 4'h0)   bnd = ymin_i;
    else if ((ec1 & OC_RIGHT) != 4'h0) bnd = xmax_i;
    else                               bnd = ymax_i;
    pa      = sel_x ? ey1 : ex1;
    pb      = sel_x ? ey2 : ex2;
    ea      = sel_x ? ex1 : ey1;
    eb      = sel_x ? ex2 : ey2;
    d_other = DW'(pb) - DW'(pa);
    to_bnd  = DW'(bnd) - DW'(ea);
    d_edge  = DW'(eb) - DW'(ea);
  end

  // Divider step and pass result.
  logic [DW:0]          remsh;
  logic                 ge;
  logic signed [DW:0]   sq;
  logic signed [CW-1:0] base, newv, nx1, ny1;

  always_comb begin
    remsh = {rem_q[DW-1:0], prod_q[PW-1]};
    ge    = (remsh >= {1'b0, mag_d_q});
    sq    = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
    base  = sel_x_q ? y1_q : x1_q;
    newv  = CW'((DW + 1)'(base) + sq);
    nx1   = sel_x_q ? bound_q : newv;
    ny1   = sel_x_q ? newv : bound_q;
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = S_EVAL;
        end
      end
      S_EVAL:  state_d = done ? S_OUT : S_MUL;
      S_MUL:   if (cnt_q == CNW'(DW - 1)) state_d = S_DIV;
      S_DIV:   if (cnt_q == CNW'(PW - 1)) state_d = S_UPD;
      S_UPD:   state_d = S_EVAL;
      S_OUT:   if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      passes_q    <= '0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_OUT) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE:  passes_q <= '0;
        S_EVAL:  cnt_q <= '0;
        S_MUL:   cnt_q <= (cnt_q == CNW'(DW - 1)) ? '0 : cnt_q + 1'b1;
        S_DIV:   cnt_q <= cnt_q + 1'b1;
        S_UPD:   passes_q <= passes_q + 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        {c1_q, c2_q, x1_q, y1_q, x2_q, y2_q} <= head_i;
      end
      S_EVAL: begin
        // endpoints stay in place once the segment is settled
        if (!done) begin
          x1_q    <= ex1;
          y1_q    <= ey1;
          x2_q    <= ex2;
          y2_q    <= ey2;
          c1_q    <= ec1;
          c2_q    <= sw ? 4'h0 : c2_q;
          sel_x_q <= sel_x;
          bound_q <= bnd;
          neg_q   <= d_other[DW-1] ^ to_bnd[DW-1] ^ d_edge[DW-1];
          mcand_q <= PW'(d_other[DW-1] ? DW'(-d_other) : DW'(d_other));
          mag_b_q <= to_bnd[DW-1] ? DW'(-to_bnd) : DW'(to_bnd);
          mag_d_q <= d_edge[DW-1] ? DW'(-d_edge) : DW'(d_edge);
          prod_q  <= '0;
          rem_q   <= '0;
          q_q     <= '0;
        end
      end
      S_MUL: begin
        if (mag_b_q[0]) prod_q <= prod_q + mcand_q;
        mcand_q <= mcand_q << 1;
        mag_b_q <= mag_b_q >> 1;
      end
      S_DIV: begin
        prod_q <= prod_q << 1;
        rem_q  <= ge ? remsh - {1'b0, mag_d_q} : remsh;
        q_q    <= {q_q[DW-2:0], ge};
      end
      S_UPD: begin
        // A zero divisor yields a zero quotient.
        x1_q <= (mag_d_q == '0) ? (sel_x_q ? bound_q : x1_q) : nx1;
        y1_q <= (mag_d_q == '0) ? (sel_x_q ? y1_q : bound_q) : ny1;
        c1_q <= lco_outcode(LCO_CW_MAX'((mag_d_q == '0) ? (sel_x_q ? bound_q : x1_q) : nx1),
                            LCO_CW_MAX'((mag_d_q == '0) ? (sel_x_q ? y1_q : bound_q) : ny1),
                            LCO_CW_MAX'(xmin_i), LCO_CW_MAX'(ymin_i),
                            LCO_CW_MAX'(xmax_i), LCO_CW_MAX'(ymax_i));
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          rej_q <= ((c1_q | c2_q) != 4'h0);
          ox1_q <= 32'(x1_q);
          oy1_q <= 32'(y1_q);
          ox2_q <= 32'(x2_q);
          oy2_q <= 32'(y2_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign rejected_o        = rej_q;
  assign clipped_start_x_o = ox1_q;
  assign clipped_start_y_o = oy1_q;
  assign clipped_end_x_o   = ox2_q;
  assign clipped_end_y_o   = oy2_q;

  `LCO_ASSERT_NOW(a_div_nonzero, state_q == S_DIV, mag_d_q != '0, "clip pass with zero divisor")
  `LCO_ASSERT_NOW(a_pass_cap, 1'b1, passes_q <= PSW'(MAX_PASSES), "pass counter past cap")
  `LCO_ASSERT_NEXT(a_far_fixed, state_q == S_UPD, $stable(c2_q) && $stable(x2_q),
                   "far endpoint moved during a clip pass")
endmodule

// ----- src/line_clip_outcode.sv -----
// Top level of the outcode line clipper: config registers, classifier,
// queue and clip engine. Depends on lco_pkg, lco_front, lco_fifo, lco_back.
//
// Clips one segment (two endpoints, signed fixed point with FRAC_BITS
// fraction bits) against the window [left, right-1] x [top, bottom-1] in
// pixels and returns one result per segment: a reject flag and the final
// endpoints, possibly swapped. The front end takes a transfer whenever the
// two-entry queue has room and tags both endpoints with outcodes; the clip
// engine then works on one segment at a time, making 0 to MAX_PASSES clip
// passes. CW = max(33, FRAC_BITS + 15) is the internal coordinate width;
// each pass runs a bit-serial multiply over CW + 1 bits and a restoring
// divide over the full product. Throughput is set by the shared
// multiply/divide unit. Reaching the pass cap with an endpoint still outside
// reports a reject. The user must write the window registers through the
// config port only while the block is idle; the block itself does not
// enforce this. A write is taken every cycle.
module line_clip_outcode import lco_pkg::*; #(
  parameter int FRAC_BITS  = LCO_FRAC_BITS,
  parameter int MAX_PASSES = LCO_MAX_PASSES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [LCO_CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LCO_BOUND_W-1:0]   cfg_data_i,
  // segment input
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [31:0]       start_x_i,
  input  logic signed [31:0]       start_y_i,
  input  logic signed [31:0]       end_x_i,
  input  logic signed [31:0]       end_y_i,
  // result output
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     rejected_o,
  output logic signed [31:0]       clipped_start_x_o,
  output logic signed [31:0]       clipped_start_y_o,
  output logic signed [31:0]       clipped_end_x_o,
  output logic signed [31:0]       clipped_end_y_o
);
  localparam int CW = lco_coord_w(FRAC_BITS);
  localparam int EW = 4 * CW + 8;

  logic [LCO_BOUND_W-1:0] left_q, top_q, right_q, bottom_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      right_q  <= LCO_BOUND_W'(4096);
      bottom_q <= LCO_BOUND_W'(4096);
    end else if (cfg_valid_i) begin
      case (lco_cfg_e'(cfg_index_i))
        CFG_LEFT:   left_q   <= cfg_data_i;
        CFG_TOP:    top_q    <= cfg_data_i;
        CFG_RIGHT:  right_q  <= cfg_data_i;
        CFG_BOTTOM: bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Window in fixed point; max side pulled in by one pixel.
  logic signed [LCO_BOUND_W:0] rm1, bm1;
  logic signed [CW-1:0]        xmin, ymin, xmax, ymax;

  assign rm1  = $signed({1'b0, right_q}) - 14'sd1;
  assign bm1  = $signed({1'b0, bottom_q}) - 14'sd1;
  assign xmin = CW'($signed({1'b0, left_q})) <<< FRAC_BITS;
  assign ymin = CW'($signed({1'b0, top_q})) <<< FRAC_BITS;
  assign xmax = CW'(rm1) <<< FRAC_BITS;
  assign ymax = CW'(bm1) <<< FRAC_BITS;

  logic          push, full, pop, empty;
  logic [EW-1:0] push_data, head;

  lco_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .in_valid_i, .in_ready_o, .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .xmin_i(xmin), .ymin_i(ymin), .xmax_i(xmax), .ymax_i(ymax),
    .full_i(full), .push_o(push), .push_data_o(push_data)
  );

  lco_fifo #(.WIDTH(EW)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .empty_o(empty), .head_o(head)
  );

  lco_back #(.FRAC_BITS(FRAC_BITS), .MAX_PASSES(MAX_PASSES)) u_back (
    .clk_i, .rst_ni,
    .xmin_i(xmin), .ymin_i(ymin), .xmax_i(xmax), .ymax_i(ymax),
    .empty_i(empty), .head_i(head), .pop_o(pop),
    .out_valid_o, .out_ready_i, .rejected_o,
    .clipped_start_x_o, .clipped_start_y_o, .clipped_end_x_o, .clipped_end_y_o
  );
endmodule
